### design/vmb_pkg.sv
// Shared constants, types and latency figures of the view matrix builder.
package vmb_pkg;

	// Square root pipe: stages and digit steps per stage (32 root bits in all)
	localparam int unsigned SQ_STG = 8;
	localparam int unsigned SQ_PER = 32 / SQ_STG;
	// Division pipe: stages and quotient bits per stage (32 bits in all)
	localparam int unsigned DV_STG = 8;
	localparam int unsigned DV_PER = 32 / DV_STG;
	// Normalizer latency: lead search, shift, square, sum, then the two pipes
	localparam int unsigned UNIT_LAT = 4 + SQ_STG + DV_STG;

	// floor(2^120 * 1e-24): squared-length limit of right in units 2^-120
	localparam logic [43:0] RIGHT_LIMIT = 44'd1329227995784;

	localparam logic [1:0] ROW_RIGHT = 2'd0;
	localparam logic [1:0] ROW_UP    = 2'd1;
	localparam logic [1:0] ROW_FWD   = 2'd2;

	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

	// Vector handed to a normalizer: magnitudes and signs of three entries
	typedef struct packed {
		logic [2:0][63:0] mag;
		logic [2:0]       neg;
	} vmb_vec_t;

	// Side band that travels beside the normalizers
	typedef struct packed {
		logic             bad;
		logic [2:0][32:0] d;
	} vmb_side_t;

endpackage

### design/view_matrix_builder_unit.sv
// Top level of the view matrix builder: look-at rows from camera basis and position.
//
//  channel  direction  fields                                        handshake
//  s_*      in         up_x..z, back_x..z, pos_x..z (tdata)          tvalid/tready
//  m_*      out        row_index, elem_x..z, shift_term (tdata),     tvalid/tready
//                      last_row (tlast), bad_basis (tuser)
//  cfg_*    in         origin_x/y/z by index                         write enable
//
// Pipeline: 30 register stages from input to the output register; the two
// normalizers (square root and divide pipes, 4 bits a stage) set most of it.
// Each item leaves as three rows (one for a bad basis), and no new item enters
// until the held item's last row is taken, so the output register sets the rate.
// Reset clears the origin registers, all valid bits and the row counter.
// A stall at the output freezes every stage together; nothing is lost.
module view_matrix_builder_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,  // up_x, up_y, up_z, back_x, back_y, back_z, pos_x, pos_y, pos_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // row_index, elem_x, elem_y, elem_z, shift_term, zero pad
	output logic         m_tlast,  // last_row
	output logic         m_tuser,  // bad_basis
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_data
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] sh;
	} row_t;

	typedef struct packed {
		row_t [2:0] rows;
		logic       bad;
	} hold_t;

	// round to Q2.30, ties away from zero, saturate
	function automatic logic [31:0] q30_sat(input logic signed [64:0] v);
		logic [64:0] mg;
		logic [35:0] m;
		logic [31:0] res;
		mg = v[64] ? 65'(-v) : 65'(v);
		m  = 36'((mg + 65'd536870912) >> 30);
		if (v[64]) res = (m > 36'd2147483648) ? 32'h80000000 : 32'(36'd0 - m);
		else res = (m > 36'd2147483647) ? 32'h7fffffff : m[31:0];
		return res;
	endfunction

	// translation: round the dot product to Q16.16 (ties up), negate, saturate
	function automatic logic [31:0] shift_sat(input logic signed [64:0] a,
		input logic signed [64:0] b, input logic signed [64:0] c);
		logic signed [66:0] s;
		logic signed [36:0] t;
		logic signed [37:0] ng;
		logic [31:0]        res;
		s  = 67'(a) + 67'(b) + 67'(c) + 67'sd536870912;
		t  = 37'(s >>> 30);
		ng = -38'(t);
		if (ng > 38'sd2147483647) res = 32'h7fffffff;
		else if (ng < -38'sd2147483648) res = 32'h80000000;
		else res = ng[31:0];
		return res;
	endfunction

	logic [2:0][31:0] org_q;
	logic             en;
	logic             last_c;
	logic [1:0]       row_q;
	hold_t            hold_q;
	logic             hold_vld_q;

	logic signed [31:0] up_c   [3];
	logic signed [31:0] back_c [3];
	logic signed [31:0] pos_c  [3];

	logic               v_s1;
	logic signed [32:0] f_s1 [3];
	logic signed [31:0] u_s1 [3];
	logic signed [32:0] d_s1 [3];

	logic               v_s2, fz_s2;
	logic signed [64:0] prod_s2 [6];
	logic signed [32:0] f_s2 [3];
	logic signed [32:0] d_s2 [3];

	logic               v_s3, fz_s3;
	logic signed [65:0] r_s3 [3];
	logic signed [32:0] f_s3 [3];
	logic signed [32:0] d_s3 [3];

	logic [2:0][63:0]   rmag_c;
	logic               small_c;
	logic               v_s4, fz_s4, small_s4;
	logic [2:0][63:0]   rmag_s4;
	logic [2:0]         rneg_s4;
	logic [2:0][31:0]   fmag_s4;
	logic [2:0]         fneg_s4;
	logic [41:0]        rsq_s4 [3];
	logic signed [32:0] d_s4 [3];

	logic               v_s5;
	vmb_pkg::vmb_vec_t  fvec_s5;
	vmb_pkg::vmb_vec_t  rvec_s5;
	vmb_pkg::vmb_side_t side_s5;

	vmb_pkg::vmb_side_t            dly_side_q [1:vmb_pkg::UNIT_LAT];
	logic [vmb_pkg::UNIT_LAT:1]    dly_vld_q;
	logic [2:0][31:0]              fn_c;
	logic [2:0][31:0]              rn_c;

	logic               v_s6, bad_s6;
	logic signed [31:0] rn_s6 [3];
	logic signed [31:0] fn_s6 [3];
	logic signed [31:0] nf_s6 [3];
	logic signed [32:0] d_s6  [3];

	logic               v_s7, bad_s7;
	logic signed [63:0] tp_s7 [6];
	logic signed [64:0] rd_s7 [3];
	logic signed [64:0] nd_s7 [3];
	logic signed [31:0] rn_s7 [3];
	logic signed [31:0] nf_s7 [3];
	logic signed [32:0] d_s7  [3];

	logic               v_s8, bad_s8;
	logic signed [31:0] tu_s8 [3];
	logic [31:0]        shr_s8, shf_s8;
	logic signed [31:0] rn_s8 [3];
	logic signed [31:0] nf_s8 [3];
	logic signed [32:0] d_s8  [3];

	logic               v_s9, bad_s9;
	logic signed [64:0] ud_s9 [3];
	logic signed [31:0] tu_s9 [3];
	logic signed [31:0] rn_s9 [3];
	logic signed [31:0] nf_s9 [3];
	logic [31:0]        shr_s9, shf_s9;

	// Origin registers: writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				vmb_pkg::REG_ORIGIN_X: org_q[0] <= cfg_data;
				vmb_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_data;
				vmb_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipe advances when the output register is free or about to free
	assign last_c   = hold_q.bad || (row_q == vmb_pkg::ROW_FWD);
	assign en       = !hold_vld_q || (m_tready && last_c);
	assign s_tready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			up_c[i]   = $signed(s_tdata[32*i +: 32]);
			back_c[i] = $signed(s_tdata[96 + 32*i +: 32]);
			pos_c[i]  = $signed(s_tdata[192 + 32*i +: 32]);
		end
	end

	// Right magnitudes and the short-vector test
	always_comb begin
		small_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			rmag_c[i] = r_s3[i][65] ? 64'(-r_s3[i]) : 64'(r_s3[i]);
			if (rmag_c[i][63:21] != '0) small_c = 1'b0;
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			dly_vld_q <= '0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			hold_vld_q <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dly_vld_q <= {dly_vld_q[vmb_pkg::UNIT_LAT-1:1], v_s5};
			v_s6 <= dly_vld_q[vmb_pkg::UNIT_LAT];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			hold_vld_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: forward, offset position
			for (int i = 0; i < 3; i++) begin
				f_s1[i] <= 33'sd0 - 33'(back_c[i]);
				u_s1[i] <= up_c[i];
				d_s1[i] <= 33'(pos_c[i]) - 33'($signed(org_q[i]));
			end
			// stage 2: cross product terms of forward and up
			prod_s2[0] <= f_s1[1] * u_s1[2];
			prod_s2[1] <= f_s1[2] * u_s1[1];
			prod_s2[2] <= f_s1[2] * u_s1[0];
			prod_s2[3] <= f_s1[0] * u_s1[2];
			prod_s2[4] <= f_s1[0] * u_s1[1];
			prod_s2[5] <= f_s1[1] * u_s1[0];
			fz_s2 <= (f_s1[0] == '0) && (f_s1[1] == '0) && (f_s1[2] == '0);
			f_s2 <= f_s1;
			d_s2 <= d_s1;
			// stage 3: right
			r_s3[0] <= 66'(prod_s2[0]) - 66'(prod_s2[1]);
			r_s3[1] <= 66'(prod_s2[2]) - 66'(prod_s2[3]);
			r_s3[2] <= 66'(prod_s2[4]) - 66'(prod_s2[5]);
			fz_s3 <= fz_s2;
			f_s3 <= f_s2;
			d_s3 <= d_s2;
			// stage 4: magnitudes, signs, squares for the length test
			for (int i = 0; i < 3; i++) begin
				rmag_s4[i] <= rmag_c[i];
				rneg_s4[i] <= r_s3[i][65];
				rsq_s4[i]  <= rmag_c[i][20:0] * rmag_c[i][20:0];
				fmag_s4[i] <= f_s3[i][32] ? 32'(-f_s3[i]) : 32'(f_s3[i]);
				fneg_s4[i] <= f_s3[i][32];
			end
			small_s4 <= small_c;
			fz_s4 <= fz_s3;
			d_s4 <= d_s3;
			// stage 5: degenerate basis verdict, hand over to the normalizers
			side_s5.bad <= fz_s4 || (small_s4 &&
				((44'(rsq_s4[0]) + 44'(rsq_s4[1]) + 44'(rsq_s4[2])) <= vmb_pkg::RIGHT_LIMIT));
			for (int i = 0; i < 3; i++) begin
				side_s5.d[i]    <= d_s4[i];
				fvec_s5.mag[i]  <= 64'(fmag_s4[i]);
				rvec_s5.mag[i]  <= rmag_s4[i];
			end
			fvec_s5.neg <= fneg_s4;
			rvec_s5.neg <= rneg_s4;
			// side band beside the normalizers
			dly_side_q[1] <= side_s5;
			for (int k = 2; k <= int'(vmb_pkg::UNIT_LAT); k++) dly_side_q[k] <= dly_side_q[k-1];
			// stage 6: unit vectors
			for (int i = 0; i < 3; i++) begin
				rn_s6[i] <= $signed(rn_c[i]);
				fn_s6[i] <= $signed(fn_c[i]);
				nf_s6[i] <= $signed(32'd0 - fn_c[i]);
				d_s6[i]  <= $signed(dly_side_q[vmb_pkg::UNIT_LAT].d[i]);
			end
			bad_s6 <= dly_side_q[vmb_pkg::UNIT_LAT].bad;
			// stage 7: true-up terms and dot products of right and back
			tp_s7[0] <= rn_s6[1] * fn_s6[2];
			tp_s7[1] <= rn_s6[2] * fn_s6[1];
			tp_s7[2] <= rn_s6[2] * fn_s6[0];
			tp_s7[3] <= rn_s6[0] * fn_s6[2];
			tp_s7[4] <= rn_s6[0] * fn_s6[1];
			tp_s7[5] <= rn_s6[1] * fn_s6[0];
			for (int i = 0; i < 3; i++) begin
				rd_s7[i] <= rn_s6[i] * d_s6[i];
				nd_s7[i] <= nf_s6[i] * d_s6[i];
			end
			rn_s7 <= rn_s6; nf_s7 <= nf_s6; d_s7 <= d_s6; bad_s7 <= bad_s6;
			// stage 8: true up, translations of right and back
			tu_s8[0] <= $signed(q30_sat(65'(tp_s7[0]) - 65'(tp_s7[1])));
			tu_s8[1] <= $signed(q30_sat(65'(tp_s7[2]) - 65'(tp_s7[3])));
			tu_s8[2] <= $signed(q30_sat(65'(tp_s7[4]) - 65'(tp_s7[5])));
			shr_s8 <= shift_sat(rd_s7[0], rd_s7[1], rd_s7[2]);
			shf_s8 <= shift_sat(nd_s7[0], nd_s7[1], nd_s7[2]);
			rn_s8 <= rn_s7; nf_s8 <= nf_s7; d_s8 <= d_s7; bad_s8 <= bad_s7;
			// stage 9: dot product of true up
			for (int i = 0; i < 3; i++) ud_s9[i] <= tu_s8[i] * d_s8[i];
			tu_s9 <= tu_s8; rn_s9 <= rn_s8; nf_s9 <= nf_s8;
			shr_s9 <= shr_s8; shf_s9 <= shf_s8; bad_s9 <= bad_s8;
			// output register: three rows, zero for a bad basis
			hold_q.bad <= bad_s9;
			hold_q.rows[0] <= bad_s9 ? '0 : {rn_s9[0], rn_s9[1], rn_s9[2], shr_s9};
			hold_q.rows[1] <= bad_s9 ? '0 : {tu_s9[0], tu_s9[1], tu_s9[2],
				shift_sat(ud_s9[0], ud_s9[1], ud_s9[2])};
			hold_q.rows[2] <= bad_s9 ? '0 : {nf_s9[0], nf_s9[1], nf_s9[2], shf_s9};
		end
	end

	vmb_unit_pipe u_fwd (
		.clk  (clk),
		.en   (en),
		.vin  (fvec_s5),
		.vout (fn_c)
	);

	vmb_unit_pipe u_rgt (
		.clk  (clk),
		.en   (en),
		.vin  (rvec_s5),
		.vout (rn_c)
	);

	// Row counter: advance on each taken row, restart after the last row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= vmb_pkg::ROW_RIGHT;
		end else if (hold_vld_q && m_tready) begin
			row_q <= last_c ? vmb_pkg::ROW_RIGHT : row_q + 2'd1;
		end
	end

	row_t row_c;

	always_comb begin
		case (row_q)
			vmb_pkg::ROW_RIGHT: row_c = hold_q.rows[0];
			vmb_pkg::ROW_UP:    row_c = hold_q.rows[1];
			default:            row_c = hold_q.rows[2];
		endcase
	end

	assign m_tvalid = hold_vld_q;
	assign m_tdata  = {6'd0, row_c.sh, row_c.z, row_c.y, row_c.x, row_q};
	assign m_tlast  = last_c;
	assign m_tuser  = hold_q.bad;

endmodule

### design/vmb_unit_pipe.sv
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
module vmb_unit_pipe (
	input  logic              clk,
	input  logic              en,
	input  vmb_pkg::vmb_vec_t vin,
	output logic [2:0][31:0]  vout
);

	typedef struct packed {
		logic [35:0]      rem;
		logic [31:0]      root;
		logic [63:0]      rad;
		logic [2:0][30:0] m;
		logic [2:0]       neg;
	} sq_st_t;

	typedef struct packed {
		logic [2:0][31:0] rem;
		logic [2:0][31:0] low;
		logic [31:0]      n;
		logic [2:0]       neg;
	} dv_st_t;

	function automatic sq_st_t sq_step(input sq_st_t a);
		sq_st_t      b;
		logic [35:0] r2;
		logic [35:0] tr;
		b = a;
		for (int j = 0; j < int'(vmb_pkg::SQ_PER); j++) begin
			r2 = {b.rem[33:0], b.rad[63:62]};
			tr = {2'b00, b.root, 2'b01};
			b.rad = {b.rad[61:0], 2'b00};
			if (r2 >= tr) begin
				b.rem  = r2 - tr;
				b.root = {b.root[30:0], 1'b1};
			end else begin
				b.rem  = r2;
				b.root = {b.root[30:0], 1'b0};
			end
		end
		return b;
	endfunction

	function automatic dv_st_t dv_init(input sq_st_t a);
		dv_st_t      b;
		logic [61:0] num;
		b.n   = a.root;
		b.neg = a.neg;
		for (int l = 0; l < 3; l++) begin
			// round half up: add half the divisor before the divide
			num = {1'b0, a.m[l], 30'd0} + {31'd0, a.root[31:1]};
			b.rem[l] = {2'b00, num[61:32]};
			b.low[l] = num[31:0];
		end
		return b;
	endfunction

	function automatic dv_st_t dv_step(input dv_st_t a);
		dv_st_t      b;
		logic [32:0] r2;
		logic        qb;
		b = a;
		for (int l = 0; l < 3; l++) begin
			for (int j = 0; j < int'(vmb_pkg::DV_PER); j++) begin
				r2 = {b.rem[l], b.low[l][31]};
				qb = (r2 >= {1'b0, b.n});
				b.low[l] = {b.low[l][30:0], qb};
				b.rem[l] = qb ? 32'(r2 - {1'b0, b.n}) : r2[31:0];
			end
		end
		return b;
	endfunction

	logic [63:0]      ormag;
	logic [5:0]       lead_c;
	logic [2:0][63:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [5:0]       lead_s1;
	logic [2:0][30:0] norm_c;
	logic [2:0][30:0] norm_s2;
	logic [2:0]       neg_s2;
	logic [2:0][61:0] sqr_s3;
	logic [2:0][30:0] norm_s3;
	logic [2:0]       neg_s3;
	sq_st_t           sqrt_s [vmb_pkg::SQ_STG+1];
	dv_st_t           div_s  [vmb_pkg::DV_STG];

	// leading one of the largest entry equals that of the entries or-ed
	assign ormag = vin.mag[0] | vin.mag[1] | vin.mag[2];

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < 64; i++) begin
			if (ormag[i]) lead_c = 6'(i);
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (lead_s1 >= 6'd30) norm_c[l] = 31'(mag_s1[l] >> (lead_s1 - 6'd30));
			else norm_c[l] = 31'(mag_s1[l] << (6'd30 - lead_s1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= vin.mag;
			neg_s1  <= vin.neg;
			lead_s1 <= lead_c;
			norm_s2 <= norm_c;
			neg_s2  <= neg_s1;
			for (int l = 0; l < 3; l++) sqr_s3[l] <= norm_s2[l] * norm_s2[l];
			norm_s3 <= norm_s2;
			neg_s3  <= neg_s2;
			sqrt_s[0].rem  <= '0;
			sqrt_s[0].root <= '0;
			sqrt_s[0].rad  <= 64'(sqr_s3[0]) + 64'(sqr_s3[1]) + 64'(sqr_s3[2]);
			sqrt_s[0].m    <= norm_s3;
			sqrt_s[0].neg  <= neg_s3;
			for (int k = 1; k <= int'(vmb_pkg::SQ_STG); k++) sqrt_s[k] <= sq_step(sqrt_s[k-1]);
			div_s[0] <= dv_step(dv_init(sqrt_s[vmb_pkg::SQ_STG]));
			for (int k = 1; k < int'(vmb_pkg::DV_STG); k++) div_s[k] <= dv_step(div_s[k-1]);
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			vout[l] = div_s[vmb_pkg::DV_STG-1].neg[l] ?
				(32'd0 - div_s[vmb_pkg::DV_STG-1].low[l]) : div_s[vmb_pkg::DV_STG-1].low[l];
		end
	end

endmodule

### design/vmb_checker.sv
// Port-level checks of the view matrix builder output channel, with bind.
module vmb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata,
	input logic         m_tlast,
	input logic         m_tuser
);

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// a bad basis is one all-zero item
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("bad basis item not a single zero item");

	// a valid basis ends on the negated forward row
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && !m_tuser |-> (m_tdata[1:0] == vmb_pkg::ROW_FWD))
		else $error("last row of a valid basis is not row two");

	// rows of one item follow without a gap, in order
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1))
		else $error("row sequence broken");

endmodule

bind view_matrix_builder_unit vmb_checker u_vmb_checker (.*);
